// ===== rtl/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg
// shared constants and types of the free block bitmap allocator
// ----------------------------------------------------------------------------
package fbba_pkg;

   localparam int BITMAP_BYTES = 1024;
   localparam int IDX_W        = 13;
   localparam int FIELD_BLOCKS = 1 << IDX_W;
   localparam int TOTAL_BLOCKS = BITMAP_BYTES * 8;
   localparam int BYTE_AW      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int SCAN_BYTES   = (BITMAP_BYTES < FIELD_BLOCKS / 8) ?
                                 BITMAP_BYTES : FIELD_BLOCKS / 8;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_MARK  = 2'd2
   } req_code_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_RESP  = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

endpackage

// ===== rtl/free_block_bitmap_allocator.sv =====
// allocate: one bitmap byte per cycle through the ram read port
// free, mark: byte read, read-modify-write, result
// unknown request code: no bitmap access; one item in flight, ready low while it is worked on
// result sits in an output register, so the next item may enter while it waits
// reset: clearing pass writes zeros to all BITMAP_BYTES (1024) bytes, ready low meanwhile
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator
// first fit block allocator over a used-block bitmap held in a ram
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator
   import fbba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [IDX_W-1:0] req_block_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic [IDX_W-1:0] rsp_block_index_out
);

   localparam logic [BYTE_AW-1:0] LAST_BYTE = BYTE_AW'(BITMAP_BYTES - 1);
   localparam logic [BYTE_AW-1:0] SCAN_LAST = BYTE_AW'(SCAN_BYTES - 1);

   state_type          state_ff, state_in;
   logic [BYTE_AW-1:0] ptr_ff, ptr_in;
   logic [1:0]         req_ff, req_in;
   logic [IDX_W-1:0]   blk_ff, blk_in;
   logic               res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_index_ff, res_index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic               wr_en;
   logic [BYTE_AW-1:0] wr_addr;
   logic [7:0]         wr_data;
   logic [BYTE_AW-1:0] rd_addr;
   logic [7:0]         rd_data;

   logic [7:0]         examined;
   logic               hit;
   logic [2:0]         hit_pos;
   logic [7:0]         blk_mask;
   logic               blk_in_range;
   logic               accept;
   logic               out_free;

   fbba_ram #(
      .WIDTH (8),
      .DEPTH (BITMAP_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign blk_mask     = 8'h80 >> blk_ff[2:0];
   assign blk_in_range = 32'(blk_ff) < 32'(TOTAL_BLOCKS);

   // block 0 is the root and never handed out
   assign examined = rd_data | ((ptr_ff == '0) ? 8'h80 : 8'h00);

   // first zero bit from the msb side
   always_comb begin
      hit     = 1'b0;
      hit_pos = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!examined[i] && !hit) begin
            hit     = 1'b1;
            hit_pos = 3'(7 - i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      req_in        = req_ff;
      blk_in        = blk_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = 8'h00;
      rd_addr       = ptr_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_BYTE) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            req_in    = req_type;
            blk_in    = req_block_index;
            if (req_type == REQ_ALLOC) begin
               rd_addr = '0;
            end else begin
               rd_addr = BYTE_AW'(req_block_index >> 3);
            end
            if (accept) begin
               ptr_in = rd_addr;
               priority if (req_type == REQ_ALLOC) begin
                  state_in = ST_SCAN;
               end else if (req_type == REQ_FREE || req_type == REQ_MARK) begin
                  state_in = ST_MOD;
               end else begin
                  res_status_in = 1'b0;
                  res_index_in  = req_block_index;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = ptr_ff + 1'b1;
            ptr_in  = ptr_ff + 1'b1;
            if (hit) begin
               wr_en         = 1'b1;
               wr_data       = rd_data | (8'h80 >> hit_pos);
               res_status_in = 1'b0;
               res_index_in  = (IDX_W'(ptr_ff) << 3) | IDX_W'(hit_pos);
               state_in      = ST_RESP;
            end else if (ptr_ff == SCAN_LAST) begin
               res_status_in = 1'b1;
               res_index_in  = '0;
               state_in      = ST_RESP;
            end
         end
         ST_MOD: begin
            wr_en         = blk_in_range;
            wr_data       = (req_ff == REQ_FREE) ? (rd_data & ~blk_mask) : (rd_data | blk_mask);
            res_status_in = 1'b0;
            res_index_in  = blk_ff;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if ((state_ff == ST_RESP || state_ff == ST_HOLD) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_index_in  = res_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      blk_ff        <= blk_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_block_index_out = rsp_index_ff;

endmodule

// ===== rtl/fbba_ram.sv =====
// ----------------------------------------------------------------------------
// fbba_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fbba_checker.sv =====
// ----------------------------------------------------------------------------
// fbba_checker
// port level checks of the free block bitmap allocator
// ----------------------------------------------------------------------------
module fbba_checker
   import fbba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_status,
   input  logic [IDX_W-1:0] rsp_block_index_out
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_block_index_out))
      else $error("result changed while stalled");

   // full answer carries block zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_block_index_out == '0)
      else $error("full result with nonzero block");

   // busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // clearing pass and empty output after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("not quiet after reset");

endmodule

bind free_block_bitmap_allocator fbba_checker u_fbba_checker (.*);
